[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the sorted list intersection core.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define SLI_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sli assertion failed");

// An implication: the consequent must hold whenever the antecedent holds.
`define SLI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sli assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sli assertion failed");

`endif

[hw/rtl/sli_pkg.sv]
// Package of the sorted list intersection core: list depth default, opcodes and status codes.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package sli_pkg;

    localparam int SLI_LIST_DEPTH = 64;
    localparam int SLI_VALUE_W    = 32;

    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_FETCH    = 2'd3;

    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_MATCH    = 2'd2;
    localparam logic [1:0] STATUS_DONE     = 2'd3;

endpackage

[hw/rtl/sorted_list_intersection_core.sv]
// Top level of the sorted list intersection core: list loading and the two-pointer walk.
// Depends on sli_pkg, sli_ram and assert_macros.svh.
//
//   Channel | Ports                  | tuser           | tdata
//   input   | s_tvalid/s_tready      | [1:0] opcode    | [31:0] value
//   result  | m_tvalid/m_tready      | [1:0] status    | [31:0] match_value
//
// Appends and clears set the status register on acceptance; S_RESP copies it to the output
// register, and no new item is taken before then. A fetch steps S_WALK with the single signed
// comparator on the two RAM read ports, skipping the smaller head until a match or list end.
// Reset empties both lists and rewinds the walk; the list RAMs are not cleared.
// A result waits in the output register while the next transaction is taken; a further
// result holds the core until that register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_list_intersection_core import sli_pkg::*; #(
    parameter int LIST_DEPTH = SLI_LIST_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_tuser,  // [1:0] opcode
    input  logic [SLI_VALUE_W-1:0] s_tdata,  // [31:0] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [1:0]             m_tuser,  // [1:0] status
    output logic [SLI_VALUE_W-1:0] m_tdata   // [31:0] match_value
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_a_reg, count_a_next;
    logic [CW-1:0]          count_b_reg, count_b_next;
    logic [CW-1:0]          walk_a_reg, walk_a_next;
    logic [CW-1:0]          walk_b_reg, walk_b_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [SLI_VALUE_W-1:0] res_value_reg, res_value_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;
    logic [SLI_VALUE_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   wr_en_a, wr_en_b;
    logic [SLI_VALUE_W-1:0] rd_data_a, rd_data_b;
    logic [CW-1:0]          walk_a_inc, walk_b_inc;

    assign walk_a_inc = walk_a_reg + 1'b1;
    assign walk_b_inc = walk_b_reg + 1'b1;

    sli_ram #(
        .WIDTH(SLI_VALUE_W),
        .DEPTH(LIST_DEPTH)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_en_a),
        .wr_addr (count_a_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (walk_a_next[AW-1:0]),
        .rd_data (rd_data_a)
    );

    sli_ram #(
        .WIDTH(SLI_VALUE_W),
        .DEPTH(LIST_DEPTH)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_en_b),
        .wr_addr (count_b_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (walk_b_next[AW-1:0]),
        .rd_data (rd_data_b)
    );

    always_comb begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        walk_a_next     = walk_a_reg;
        walk_b_next     = walk_b_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en_a         = 1'b0;
        wr_en_b         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next      = S_RESP;
                    res_status_next = STATUS_ACCEPTED;
                    res_value_next  = '0;
                    unique case (s_tuser)
                        OP_APPEND_A: begin
                            if (count_a_reg == DEPTH_C) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                wr_en_a      = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end
                        OP_APPEND_B: begin
                            if (count_b_reg == DEPTH_C) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                wr_en_b      = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_a_next = '0;
                            count_b_next = '0;
                            walk_a_next  = '0;
                            walk_b_next  = '0;
                        end
                        OP_FETCH: begin
                            if (walk_a_reg >= count_a_reg || walk_b_reg >= count_b_reg) begin
                                res_status_next = STATUS_DONE;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        default: begin
                            res_status_next = STATUS_ACCEPTED;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if ($signed(rd_data_a) < $signed(rd_data_b)) begin
                    walk_a_next = walk_a_inc;
                    if (walk_a_inc >= count_a_reg) begin
                        res_status_next = STATUS_DONE;
                        state_next      = S_RESP;
                    end
                end else if ($signed(rd_data_a) > $signed(rd_data_b)) begin
                    walk_b_next = walk_b_inc;
                    if (walk_b_inc >= count_b_reg) begin
                        res_status_next = STATUS_DONE;
                        state_next      = S_RESP;
                    end
                end else begin
                    walk_a_next     = walk_a_inc;
                    walk_b_next     = walk_b_inc;
                    res_status_next = STATUS_MATCH;
                    res_value_next  = rd_data_a;
                    state_next      = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = res_value_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            walk_a_reg   <= '0;
            walk_b_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            walk_a_reg   <= walk_a_next;
            walk_b_reg   <= walk_b_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    `SLI_ASSERT(a_walk_bounded, aclk, aresetn, walk_a_reg <= count_a_reg && walk_b_reg <= count_b_reg && count_a_reg <= DEPTH_C && count_b_reg <= DEPTH_C)
    `SLI_ASSERT_IMP(a_walk_in_range, aclk, aresetn, state_reg == S_WALK, walk_a_reg < count_a_reg && walk_b_reg < count_b_reg)
    `SLI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SLI_ASSERT_IMP(a_value_zero, aclk, aresetn, m_tvalid && m_tuser != STATUS_MATCH, m_tdata == '0)

endmodule

[hw/rtl/sli_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for both list stores of the intersection core.
`timescale 1ns / 1ps

module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench of sorted_list_intersection_core: list appends, clears and match fetches,
// checked result by result against a predictor of the two-pointer walk.
// Depends on sli_pkg and the core RTL only.

module tb;
    import sli_pkg::*;

    localparam int DEPTH       = SLI_LIST_DEPTH;
    localparam int N_ITEMS     = 600;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]             status;
        logic [SLI_VALUE_W-1:0] value;
    } answer_t;

    class intersection_tracker;
        logic [SLI_VALUE_W-1:0] list_a [DEPTH];
        logic [SLI_VALUE_W-1:0] list_b [DEPTH];
        logic [6:0] count_a;
        logic [6:0] count_b;
        logic [6:0] walk_a;
        logic [6:0] walk_b;
        answer_t pending_answers [$];
        int n_requests;
        int n_errors;
        int n_match;
        int n_full;
        int n_done;

        function new();
            count_a = '0;
            count_b = '0;
            walk_a = '0;
            walk_b = '0;
            n_requests = 0;
            n_errors = 0;
            n_match = 0;
            n_full = 0;
            n_done = 0;
        endfunction

        // Skips the smaller head until both heads agree or a list runs out.
        function answer_t next_match();
            answer_t ans;
            ans.status = STATUS_DONE;
            ans.value = '0;
            while (walk_a < count_a && walk_b < count_b) begin
                if ($signed(list_a[walk_a]) < $signed(list_b[walk_b])) begin
                    walk_a++;
                end else if ($signed(list_a[walk_a]) > $signed(list_b[walk_b])) begin
                    walk_b++;
                end else begin
                    ans.status = STATUS_MATCH;
                    ans.value = list_a[walk_a];
                    walk_a++;
                    walk_b++;
                    return ans;
                end
            end
            return ans;
        endfunction

        function void note_request(logic [1:0] op, logic [SLI_VALUE_W-1:0] val);
            answer_t ans;
            ans.status = STATUS_ACCEPTED;
            ans.value = '0;
            n_requests++;
            case (op)
                OP_APPEND_A: begin
                    if (count_a == DEPTH) begin
                        ans.status = STATUS_FULL;
                    end else begin
                        list_a[count_a] = val;
                        count_a++;
                    end
                end
                OP_APPEND_B: begin
                    if (count_b == DEPTH) begin
                        ans.status = STATUS_FULL;
                    end else begin
                        list_b[count_b] = val;
                        count_b++;
                    end
                end
                OP_CLEAR: begin
                    count_a = '0;
                    count_b = '0;
                    walk_a = '0;
                    walk_b = '0;
                end
                OP_FETCH: begin
                    ans = next_match();
                end
            endcase
            pending_answers.push_back(ans);
        endfunction

        function void check_result(logic [1:0] status, logic [SLI_VALUE_W-1:0] val);
            answer_t want;
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing outstanding, status %0d value %0d",
                         $time, status, $signed(val));
                n_errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                n_errors++;
            end
            if (val !== want.value) begin
                $display("%0t: match_value mismatch, expected %0d, actual %0d",
                         $time, $signed(want.value), $signed(val));
                n_errors++;
            end
            case (want.status)
                STATUS_MATCH: n_match++;
                STATUS_FULL:  n_full++;
                STATUS_DONE:  n_done++;
                default: ;
            endcase
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [1:0]             s_tuser = '0;
    logic [SLI_VALUE_W-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [1:0]             m_tuser;
    logic [SLI_VALUE_W-1:0] m_tdata;

    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    intersection_tracker tracker;

    sorted_list_intersection_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit steady_window();
        return tracker.n_requests >= 300 && tracker.n_requests < 400;
    endfunction

    // Result side: random stalls, one long hold-off, and a stretch with none.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && tracker.n_requests >= 150) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (steady_window()) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tuser, m_tdata);
        end
    end

    task automatic send(logic [1:0] op, logic [SLI_VALUE_W-1:0] val);
        while (!steady_window() && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_request(op, val);
    endtask

    function automatic int random_word();
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom_range(0, 40)) - 20;
        end
        return int'($urandom);
    endfunction

    initial begin
        int q_a [$];
        int q_b [$];
        int shared_vals [$];
        int len_a;
        int len_b;
        int share_pct;
        int n_fetch;
        int kind;
        int seq;
        int extra;

        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send(OP_APPEND_A, 32'h8000_0000);
        send(OP_APPEND_A, 32'hFFFF_FFFB);
        send(OP_APPEND_A, 32'h0000_0000);
        send(OP_APPEND_A, 32'h0000_0007);
        send(OP_APPEND_A, 32'h7FFF_FFFF);
        send(OP_APPEND_B, 32'h8000_0000);
        send(OP_APPEND_B, 32'hFFFF_FFFF);
        send(OP_APPEND_B, 32'h0000_0000);
        send(OP_APPEND_B, 32'h0000_0000);
        send(OP_APPEND_B, 32'h0000_0007);
        send(OP_APPEND_B, 32'h7FFF_FFFF);
        repeat (6) send(OP_FETCH, $urandom);
        send(OP_APPEND_A, 32'h0000_0009);
        send(OP_APPEND_B, 32'h0000_0009);
        send(OP_FETCH, 32'hFFFF_FFFF);
        send(OP_CLEAR, 32'hFFFF_FFFF);
        send(OP_FETCH, 32'h0000_0000);

        seq = 0;
        while (tracker.n_requests < N_ITEMS) begin
            kind = (seq < 2) ? seq : $urandom_range(2, 11);
            seq++;
            if (kind >= 10) begin
                repeat (10) begin
                    send(2'($urandom_range(0, 3)), $urandom);
                end
            end else begin
                case (kind)
                    0: begin
                        len_a = DEPTH + 2;
                        len_b = $urandom_range(0, 12);
                        share_pct = 50;
                    end
                    1: begin
                        len_a = DEPTH;
                        len_b = DEPTH + 2;
                        share_pct = 5;
                    end
                    9: begin
                        len_a = $urandom_range(40, DEPTH + 2);
                        len_b = $urandom_range(40, DEPTH + 2);
                        share_pct = 30;
                    end
                    default: begin
                        len_a = $urandom_range(0, 12);
                        len_b = $urandom_range(0, 12);
                        share_pct = 50;
                    end
                endcase
                shared_vals.delete();
                repeat (8) shared_vals.push_back(random_word());
                q_a.delete();
                q_b.delete();
                repeat (len_a) begin
                    if ($urandom_range(0, 99) < share_pct) begin
                        q_a.push_back(shared_vals[$urandom_range(0, 7)]);
                    end else begin
                        q_a.push_back(random_word());
                    end
                end
                repeat (len_b) begin
                    if ($urandom_range(0, 99) < share_pct) begin
                        q_b.push_back(shared_vals[$urandom_range(0, 7)]);
                    end else begin
                        q_b.push_back(random_word());
                    end
                end
                q_a.sort();
                q_b.sort();
                n_fetch = ((len_a < len_b) ? len_a : len_b) + 2;

                send(OP_CLEAR, $urandom);
                while (q_a.size() + q_b.size() > 0) begin
                    if (q_b.size() == 0 || (q_a.size() > 0 && $urandom_range(0, 1) == 1)) begin
                        send(OP_APPEND_A, q_a.pop_front());
                    end else begin
                        send(OP_APPEND_B, q_b.pop_front());
                    end
                end
                repeat (n_fetch) send(OP_FETCH, $urandom);
                if ($urandom_range(0, 3) == 0) begin
                    extra = random_word();
                    send(OP_APPEND_A, extra);
                    send(OP_APPEND_B, extra);
                    repeat (2) send(OP_FETCH, $urandom);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (tracker.pending_answers.size() != 0) @(posedge aclk);
        repeat (2 * DEPTH + 20) @(posedge aclk);

        $display("Sent %0d transactions in %0d sequences, %0d cycles.",
                 tracker.n_requests, seq, cycles);
        $display("Results: %0d matches, %0d rejected appends, %0d exhausted walks.",
                 tracker.n_match, tracker.n_full, tracker.n_done);
        if (tracker.n_errors == 0 && tracker.pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
